// ===== rtl/core/sacm_pkg.sv =====
package sacm_pkg;

  localparam int ADDR_W      = 32;
  localparam int DATA_W      = 32;
  localparam int TAG_W       = 18;
  localparam int SET_LSB     = 2;
  localparam int SET_FIELD_W = 12;
  localparam int OFF_FIELD_W = 2;
  localparam int RECIP_SHIFT = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam int SETS_DEF           = 4096;
  localparam int WAYS_DEF           = 4;
  localparam int WORDS_PER_LINE_DEF = 4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_READ,
    S_UPDATE
  } back_state_t;

  // request as it travels from front to back
  typedef struct packed {
    logic              cmd;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] wdata;
  } req_t;

  // one way of a row in the cache memory
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
  } way_t;

endpackage

// ===== rtl/core/set_assoc_cache_move_to_front_top.sv =====
// Set-associative word cache with move-to-front replacement order.
// Input channel (in_valid/in_ready): command (0 write, 1 read), a 32-bit
// word address (tag 31..14, set 13..2, offset 1..0) and write_data.
// Output channel (out_valid/out_ready): read_data and miss, one item per
// read; writes return nothing. A read hit returns the word and moves it
// to way 0; a miss returns zero data with miss set.
// cfg_write/cfg_data set the enable bit (reset 1); with enable low, items
// are taken and dropped with no state change.
// A read result passes the three front stages for the set/offset
// reduction, the queue, the memory read and the update before it shows
// on out_valid. The back end takes a new item only after it has done
// the read-then-write of the last item's cache row in the row memory.
// Reset: a clearing pass writes every row of the row memory, one per
// cycle, SETS*WORDS_PER_LINE rows (16384 at defaults); in_ready stays
// low until it ends.
// A stalled receiver holds a read in the back end; the two-entry queue
// and the front pipeline keep accepting until they fill.
module set_assoc_cache_move_to_front_top import sacm_pkg::*; #(
  parameter int SETS           = SETS_DEF,
  parameter int WAYS           = WAYS_DEF,
  parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] read_data,
  output logic              miss
);

  // one memory row per (set, word offset), holding all ways
  localparam int ROW_W = $clog2(SETS * WORDS_PER_LINE);
  localparam int Q_W   = $bits(req_t) + ROW_W;

  logic             clearing;
  logic             f_push;
  req_t             f_req;
  logic [ROW_W-1:0] f_row;
  logic             q_ready;
  logic             q_valid;
  logic             q_pop;
  logic [Q_W-1:0]   q_data;
  req_t             b_req;
  logic [ROW_W-1:0] b_row;

  sacm_front #(
    .SETS           (SETS),
    .WORDS_PER_LINE (WORDS_PER_LINE),
    .ROW_W          (ROW_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .address    (address),
    .write_data (write_data),
    .clearing   (clearing),
    .q_ready    (q_ready),
    .q_push     (f_push),
    .q_req      (f_req),
    .q_row      (f_row)
  );

  // decouples the front pipeline from the back end's read-then-update of each row
  sacm_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_data  ({f_req, f_row}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  assign b_req = req_t'(q_data[Q_W-1:ROW_W]);
  assign b_row = q_data[ROW_W-1:0];

  sacm_back #(
    .SETS           (SETS),
    .WAYS           (WAYS),
    .WORDS_PER_LINE (WORDS_PER_LINE),
    .ROW_W          (ROW_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_req     (b_req),
    .q_row     (b_row),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .miss      (miss)
  );

endmodule

// ===== rtl/core/sacm_ram.sv =====
module sacm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sacm_queue.sv =====
module sacm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/sacm_front.sv =====
module sacm_front import sacm_pkg::*; #(
  parameter int SETS           = SETS_DEF,
  parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF,
  parameter int ROW_W          = $clog2(SETS * WORDS_PER_LINE)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [ADDR_W-1:0] address,
  input  logic [DATA_W-1:0] write_data,
  input  logic              clearing,
  input  logic              q_ready,
  output logic              q_push,
  output req_t              q_req,
  output logic [ROW_W-1:0]  q_row
);

  localparam int PROD_W = SET_FIELD_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((1 << RECIP_SHIFT) / SETS);
  localparam int SETS_W = $clog2(SETS + 1);
  localparam int QD_W   = SET_FIELD_W + SETS_W;
  localparam int REM_W  = ((SET_FIELD_W > SETS_W) ? SET_FIELD_W : SETS_W) + 1;

  logic enable;
  logic adv;

  // stage a: captured request
  logic                   a_valid;
  req_t                   a_req;
  logic [SET_FIELD_W-1:0] a_x;
  logic [ROW_W-1:0]       a_base;
  // stage b: quotient estimate
  logic                   b_valid;
  req_t                   b_req;
  logic [SET_FIELD_W-1:0] b_x;
  logic [ROW_W-1:0]       b_base;
  logic [SET_FIELD_W-1:0] b_q;
  // stage c: quotient times SETS
  logic                   c_valid;
  req_t                   c_req;
  logic [SET_FIELD_W-1:0] c_x;
  logic [ROW_W-1:0]       c_base;
  logic [SET_FIELD_W-1:0] c_qd;

  logic [4:0]             word_red;
  logic [PROD_W-1:0]      prod;
  logic [QD_W-1:0]        qd_full;
  logic [REM_W-1:0]       rem0;
  logic [REM_W-1:0]       rem;

  assign adv      = !c_valid || q_ready;
  assign in_ready = adv && !clearing;

  // offset mod WORDS_PER_LINE; offset < 4 so three steps suffice
  always_comb begin
    word_red = 5'(address[OFF_FIELD_W-1:0]);
    for (int i = 0; i < 3; i++) begin
      if (word_red >= 5'(WORDS_PER_LINE)) begin
        word_red = word_red - 5'(WORDS_PER_LINE);
      end
    end
  end

  assign prod    = PROD_W'(a_x) * PROD_W'(RECIP);
  assign qd_full = QD_W'(b_q) * QD_W'(SETS);

  // estimate is low by at most one, so one correction step
  always_comb begin
    rem0 = REM_W'(c_x) - REM_W'(c_qd);
    rem  = (rem0 >= REM_W'(SETS)) ? rem0 - REM_W'(SETS) : rem0;
  end

  assign q_push = c_valid && q_ready;
  assign q_req  = c_req;
  assign q_row  = c_base + ROW_W'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b1;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        enable <= cfg_data;
      end
      if (adv) begin
        // disabled block takes the item and drops it
        a_valid <= in_valid && in_ready && enable;
        b_valid <= a_valid;
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_req.cmd   <= command;
      a_req.tag   <= address[ADDR_W-1 -: TAG_W];
      a_req.wdata <= write_data;
      a_x         <= address[SET_LSB +: SET_FIELD_W];
      a_base      <= ROW_W'(int'(word_red) * SETS);
      b_req       <= a_req;
      b_x         <= a_x;
      b_base      <= a_base;
      b_q         <= prod[PROD_W-1:RECIP_SHIFT];
      c_req       <= b_req;
      c_x         <= b_x;
      c_base      <= b_base;
      c_qd        <= qd_full[SET_FIELD_W-1:0];
    end
  end

endmodule

// ===== rtl/core/sacm_back.sv =====
module sacm_back import sacm_pkg::*; #(
  parameter int SETS           = SETS_DEF,
  parameter int WAYS           = WAYS_DEF,
  parameter int WORDS_PER_LINE = WORDS_PER_LINE_DEF,
  parameter int ROW_W          = $clog2(SETS * WORDS_PER_LINE)
) (
  input  logic              clk,
  input  logic              rst,
  output logic              clearing,
  input  logic              q_valid,
  input  req_t              q_req,
  input  logic [ROW_W-1:0]  q_row,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] read_data,
  output logic              miss
);

  localparam int DEPTH = SETS * WORDS_PER_LINE;
  localparam int WAY_B = $bits(way_t);
  localparam int ROW_B = WAYS * WAY_B;
  localparam int WAY_W = $clog2(WAYS);

  back_state_t state;
  back_state_t state_next;

  logic [ROW_W-1:0] clr_row;
  logic             clr_last;
  req_t             cur;
  logic [ROW_W-1:0] cur_row;

  logic             ram_we;
  logic [ROW_W-1:0] ram_waddr;
  logic [ROW_B-1:0] ram_wdata;
  logic             ram_re;
  logic [ROW_B-1:0] ram_rdata;

  way_t             ways_old [WAYS];
  way_t             ways_new [WAYS];
  logic [ROW_B-1:0] row_new;
  logic             hit;
  logic [WAY_W-1:0] hit_idx;
  logic             has_free;
  logic [WAY_W-1:0] free_idx;
  logic [WAY_W-1:0] last;
  logic [DATA_W-1:0] front_data;
  logic             is_read;
  logic             update_go;
  logic             out_load;

  sacm_ram #(
    .WIDTH (ROW_B),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_row),
    .rdata (ram_rdata)
  );

  assign clr_last = (clr_row == ROW_W'(DEPTH - 1));
  assign is_read  = (cur.cmd == CMD_READ);

  // lookup over the row read back from memory
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      ways_old[w] = way_t'(ram_rdata[w*WAY_B +: WAY_B]);
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && ways_old[w].valid && ways_old[w].tag == cur.tag) begin
        hit     = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!has_free && !ways_old[w].valid) begin
        has_free = 1'b1;
        free_idx = WAY_W'(w);
      end
    end
  end

  // move to front: ways 1..last take their upper neighbor
  always_comb begin
    if (is_read) begin
      last       = hit_idx;
      front_data = ways_old[hit_idx].data;
    end else begin
      last       = has_free ? free_idx : WAY_W'(WAYS - 1);
      front_data = cur.wdata;
    end
    ways_new[0].valid = 1'b1;
    ways_new[0].tag   = cur.tag;
    ways_new[0].data  = front_data;
    for (int w = 1; w < WAYS; w++) begin
      ways_new[w] = (WAY_W'(w) <= last) ? ways_old[w-1] : ways_old[w];
    end
    for (int w = 0; w < WAYS; w++) begin
      row_new[w*WAY_B +: WAY_B] = ways_new[w];
    end
  end

  assign update_go = (state == S_UPDATE) && (!is_read || !out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (q_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (update_go) begin
          state_next = S_READ;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = 1'b0;
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_row;
    ram_wdata = row_new;
    out_load  = 1'b0;
    case (state)
      S_CLEAR: begin
        clearing  = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = clr_row;
        ram_wdata = '0;
      end
      S_READ: begin
        q_pop  = q_valid;
        ram_re = q_valid;
      end
      S_UPDATE: begin
        ram_we   = update_go && (!is_read || hit);
        out_load = update_go && is_read;
      end
      default: begin
        clearing = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_row <= clr_row + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_req;
      cur_row <= q_row;
    end
    if (out_load) begin
      read_data <= hit ? front_data : '0;
      miss      <= !hit;
    end
  end

endmodule
